// ===== hdl/lpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed chunk segmenter package
// Shared constants, beat types and the command word that passes from the
// front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcs_pkg;

  // Width of the packet length counter; the low LengthBits bits of the
  // announced length are used.
  localparam int unsigned LengthBits  = 16;

  // Command queue between front end and back end.
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntBits = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChunkSizeReset = 8'd255;
  localparam logic [7:0] MinChunkSize   = 8'd2;
  localparam logic [7:0] TermByte       = 8'd0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic [15:0] packet_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       packet_end;
  } res_beat_t;

  // One accepted payload byte and the framing around it.
  typedef struct packed {
    logic       has_prefix;
    logic [7:0] prefix;
    logic [7:0] data;
    logic       data_ce;
    logic       has_term;
  } seg_cmd_t;

endpackage : lpcs_pkg

`default_nettype wire

// ===== hdl/lpcs_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front end
// Tracks packet and chunk counters and turns every accepted byte of an open
// packet into one framing command for the back end; other bytes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_front import lpcs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire in_beat_t   in_i,
  input  wire logic [7:0] chunk_size_i,
  output logic            cmd_push_o,
  output seg_cmd_t        cmd_o
);

  logic [LengthBits-1:0] br_q, br_d, br_eff, br_dec;
  logic [7:0]            cbl_q, cbl_d, cbl_eff, cbl_new, cbl_dec;
  logic [7:0]            ccl_q, ccl_d, ccl_eff, ccl_new;
  logic [7:0]            size, maxp, pfx;
  logic                  need_prefix, last_byte;

  always_comb begin
    size    = (chunk_size_i < MinChunkSize) ? MinChunkSize : chunk_size_i;
    maxp    = size - 8'd1;
    br_eff  = in_i.first_of_packet ? LengthBits'(in_i.packet_length) : br_q;
    cbl_eff = in_i.first_of_packet ? 8'd0 : cbl_q;
    ccl_eff = in_i.first_of_packet ? 8'd0 : ccl_q;

    need_prefix = (cbl_eff == 8'd0);
    pfx = (br_eff < LengthBits'(maxp)) ? br_eff[7:0] : maxp;
    cbl_new = need_prefix ? pfx : cbl_eff;
    ccl_new = need_prefix ? pfx : ccl_eff;
    cbl_dec = cbl_new - 8'd1;
    br_dec  = br_eff - 1'b1;
    last_byte = (br_dec == '0);

    cmd_o.has_prefix = need_prefix;
    cmd_o.prefix     = pfx;
    cmd_o.data       = in_i.data_byte;
    // On the final byte the terminator joins the chunk only if it still fits.
    cmd_o.data_ce    = last_byte ? !(({1'b0, ccl_new} + 9'd1) < {1'b0, size})
                                 : (cbl_dec == 8'd0);
    cmd_o.has_term   = last_byte;

    cmd_push_o = accept_i && (br_eff != '0);

    br_d  = br_q;
    cbl_d = cbl_q;
    ccl_d = ccl_q;
    if (accept_i) begin
      if (br_eff == '0) begin
        br_d  = br_eff;
        cbl_d = cbl_eff;
        ccl_d = ccl_eff;
      end else if (last_byte) begin
        br_d  = '0;
        cbl_d = 8'd0;
        ccl_d = 8'd0;
      end else begin
        br_d  = br_dec;
        cbl_d = cbl_dec;
        ccl_d = ccl_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q  <= '0;
      cbl_q <= 8'd0;
      ccl_q <= 8'd0;
    end else begin
      br_q  <= br_d;
      cbl_q <= cbl_d;
      ccl_q <= ccl_d;
    end
  end

endmodule : lpcs_front

`default_nettype wire

// ===== hdl/lpcs_fifo.sv =====
// ----------------------------------------------------------------------------
// Segmenter command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_fifo import lpcs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire seg_cmd_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output seg_cmd_t      data_o
);

  seg_cmd_t                mem_q [FifoDepth];
  logic [FifoPtrBits-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FifoCntBits-1:0]  cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntBits'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == FifoPtrBits'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == FifoPtrBits'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule : lpcs_fifo

`default_nettype wire

// ===== hdl/lpcs_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter back end
// Expands each command into its prefix, payload and terminator beats and
// holds the oldest beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_back import lpcs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_empty_i,
  input  wire seg_cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output res_beat_t     res_o
);

  seg_cmd_t  cur_q, cur_d;
  logic      pend_pfx_q, pend_pfx_d;
  logic      pend_dat_q, pend_dat_d;
  logic      pend_trm_q, pend_trm_d;
  logic      out_vld_q, out_vld_d;
  res_beat_t out_q, out_d;
  logic      cur_vld, out_ld, cur_last;

  assign cur_vld = pend_pfx_q || pend_dat_q || pend_trm_q;
  assign out_ld  = cur_vld && (!out_vld_q || pop_i);
  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

  always_comb begin
    pend_pfx_d = pend_pfx_q;
    pend_dat_d = pend_dat_q;
    pend_trm_d = pend_trm_q;
    cur_d      = cur_q;
    out_d      = out_q;
    cur_last   = 1'b0;

    if (pend_pfx_q) begin
      cur_last = 1'b0;
    end else if (pend_dat_q) begin
      cur_last = !pend_trm_q;
    end else begin
      cur_last = 1'b1;
    end

    // The output register only changes when its beat leaves or it is empty.
    if (out_ld) begin
      if (pend_pfx_q) begin
        out_d = '{out_byte: cur_q.prefix, chunk_end: 1'b0, packet_end: 1'b0};
      end else if (pend_dat_q) begin
        out_d = '{out_byte: cur_q.data, chunk_end: cur_q.data_ce, packet_end: 1'b0};
      end else begin
        out_d = '{out_byte: TermByte, chunk_end: 1'b1, packet_end: 1'b1};
      end
    end

    if (out_ld) begin
      if (pend_pfx_q) begin
        pend_pfx_d = 1'b0;
      end else if (pend_dat_q) begin
        pend_dat_d = 1'b0;
      end else begin
        pend_trm_d = 1'b0;
      end
    end

    cmd_pop_o = !cmd_empty_i && (!cur_vld || (out_ld && cur_last));
    if (cmd_pop_o) begin
      cur_d      = cmd_i;
      pend_pfx_d = cmd_i.has_prefix;
      pend_dat_d = 1'b1;
      pend_trm_d = cmd_i.has_term;
    end

    if (out_ld) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_pfx_q <= 1'b0;
      pend_dat_q <= 1'b0;
      pend_trm_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_pfx_q <= pend_pfx_d;
      pend_dat_q <= pend_dat_d;
      pend_trm_q <= pend_trm_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  // Every command carries its payload byte, so framing beats never stand alone.
  a_payload_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_pfx_q |-> pend_dat_q)
    else $error("prefix pending without payload byte");

  // A terminator beat always closes a transport chunk and carries a zero byte.
  a_term_closes_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.packet_end) |-> (out_q.chunk_end && out_q.out_byte == TermByte))
    else $error("terminator beat malformed");

  // A new command is taken only when the current one is used up.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (!cur_vld || (out_ld && cur_last)))
    else $error("command loaded over unfinished one");
`endif

endmodule : lpcs_back

`default_nettype wire

// ===== hdl/length_prefixed_chunk_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed chunk segmenter, top level
//
// Usage: packet bytes enter on in_i through a queue-style port; a byte is
// taken at a rising edge with push high and full low. The first byte of a
// packet sets first_of_packet and carries the packet length. Framed beats
// leave on res_o: while empty is low the oldest beat is shown, and it is
// taken at an edge with pop high. Each beat is a length prefix, a payload
// byte or the zero terminator, flagged by chunk_end and packet_end.
// The chunk size is written on the cfg channel (cfg_valid_i, always ready)
// and the user must write it only while the block is idle (not checked).
// Path: command queue, current-command register, then the output register.
// Throughput: the back end emits one beat per cycle while pop is high. A
// byte is one to three beats (prefix, payload, terminator). The front end
// takes a byte per cycle as long as the four-entry command queue has room.
// Reset: chunk size returns to 255, all counters clear, queues empty.
// Stall: when pop stays low, the output register holds its beat, the queue
// fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_chunk_segmenter_top import lpcs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input byte channel.
  input  wire logic       push,
  output logic            full,
  input  wire in_beat_t   in_i,
  // Result beat channel.
  input  wire logic       pop,
  output logic            empty,
  output res_beat_t       res_o,
  // Chunk size register write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] chunk_size_q;
  logic       accept;
  logic       cmd_push, cmd_pop, cmd_empty;
  seg_cmd_t   cmd_wr, cmd_rd;

  // The register is a plain flop, so writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= ChunkSizeReset;
    end else if (cfg_valid_i) begin
      chunk_size_q <= cfg_data_i;
    end
  end

  // A byte is taken only when the queue has room for its command, so the
  // front end never has to hold anything back.
  assign accept = push && !full;

  lpcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .chunk_size_i(chunk_size_q),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr)
  );

  lpcs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_wr),
    .full_o (full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_rd)
  );

  lpcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res_o)
  );

endmodule : length_prefixed_chunk_segmenter_top

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed chunk segmenter testbench
// Drives packet bytes into the segmenter and checks every framed output beat
// (length prefix, payload byte, zero terminator) and its chunk_end and
// packet_end flags against an in-line framing predictor. A short directed
// run covers the corner cases, then randomized packets run at several chunk
// sizes with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import lpcs_pkg::*;

  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned ResetCycles   = 8;
  // Cycles to let the block settle after the last expected beat. A dropped
  // byte produces no beat, so a drained scoreboard alone does not prove that
  // the pipeline is empty.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned FramedBytes   = 140;
  localparam int unsigned MinPhases     = 4;
  localparam int unsigned CycleLimit    = 400000;

  // Framing predictor and store of the beats still owed by the block.
  class frame_scoreboard;
    res_beat_t   owed_beats[$];
    logic [7:0]  chunk_size;
    logic [15:0] pkt_left;
    logic [7:0]  chunk_left;
    logic [7:0]  chunk_len;
    int unsigned errors;

    function new();
      chunk_size = ChunkSizeReset;
      pkt_left   = '0;
      chunk_left = '0;
      chunk_len  = '0;
      errors     = 0;
    endfunction

    function void set_chunk_size(input logic [7:0] value);
      chunk_size = value;
    endfunction

    function void owe(input logic [7:0] value, input logic ce, input logic pe);
      res_beat_t beat;
      beat.out_byte   = value;
      beat.chunk_end  = ce;
      beat.packet_end = pe;
      owed_beats.push_back(beat);
    endfunction

    // Works out the beats caused by one accepted byte; returns zero when there are none.
    function int unsigned note_byte(input in_beat_t b);
      logic [7:0] size;
      logic [7:0] max_payload;
      logic [7:0] prefix;
      logic       final_ce;
      size        = (chunk_size < MinChunkSize) ? MinChunkSize : chunk_size;
      max_payload = size - 8'd1;
      if (b.first_of_packet) begin
        pkt_left   = b.packet_length;
        chunk_left = '0;
        chunk_len  = '0;
      end
      if (pkt_left == '0) return 0;

      if (chunk_left == '0) begin
        prefix     = (pkt_left < {8'd0, max_payload}) ? pkt_left[7:0] : max_payload;
        chunk_left = prefix;
        chunk_len  = prefix;
        owe(prefix, 1'b0, 1'b0);
      end
      chunk_left = chunk_left - 8'd1;
      pkt_left   = pkt_left - 16'd1;

      if (pkt_left != '0) begin
        owe(b.data_byte, chunk_left == '0, 1'b0);
        return 1 + ((chunk_len == chunk_left + 8'd1) ? 1 : 0);
      end

      // Last payload byte: the terminator shares the chunk only if it fits.
      final_ce = ({1'b0, chunk_len} + 9'd1 < {1'b0, size}) ? 1'b0 : 1'b1;
      owe(b.data_byte, final_ce, 1'b0);
      owe(TermByte, 1'b1, 1'b1);
      chunk_left = '0;
      chunk_len  = '0;
      return 2;
    endfunction

    function void check_beat(input res_beat_t got);
      res_beat_t want;
      if (owed_beats.size() == 0) begin
        $display("%0t: beat with nothing expected: got byte %h ce %b pe %b",
                 $time, got.out_byte, got.chunk_end, got.packet_end);
        errors++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.out_byte != want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h actual %h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.chunk_end != want.chunk_end) begin
        $display("%0t: chunk_end mismatch: expected %b actual %b",
                 $time, want.chunk_end, got.chunk_end);
        errors++;
      end
      if (got.packet_end != want.packet_end) begin
        $display("%0t: packet_end mismatch: expected %b actual %b",
                 $time, want.packet_end, got.packet_end);
        errors++;
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  in_beat_t   in_beat     = '0;
  logic       pop         = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic [7:0] cfg_data    = '0;
  logic       full;
  logic       empty;
  res_beat_t  res_beat;
  logic       cfg_ready;

  // The first three are shared between the stimulus and the result sink.
  frame_scoreboard framer;
  bit              no_idle      = 1'b0;
  bit              hold_request = 1'b0;
  int unsigned     framed_bytes = 0;

  always #HalfPeriod clk_i = ~clk_i;

  length_prefixed_chunk_segmenter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_beat),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Offers one input beat at a falling edge, after a random gap, and holds it
  // until a rising edge sees full low. Push stays high on return so that
  // back-to-back beats need no second assignment in the same step.
  task automatic send_byte(input logic first, input logic [15:0] len,
                           input logic [7:0] data);
    in_beat_t b;
    b.data_byte       = data;
    b.first_of_packet = first;
    b.packet_length   = len;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_beat <= b;
    do @(posedge clk_i); while (full);
    if (framer.note_byte(b) != 0) framed_bytes++;
  endtask

  // A first byte announcing len, then count-1 more bytes. A count below len
  // leaves the packet open; a count above len adds surplus bytes.
  task automatic send_packet(input int unsigned len, input int unsigned count);
    send_byte(1'b1, len[15:0], 8'($urandom_range(0, 255)));
    for (int unsigned i = 1; i < count; i++) begin
      send_byte(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Stops offering bytes and waits until every owed beat has come out and
  // the pipeline has had time to swallow any dropped bytes.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (framer.owed_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_chunk_size(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    framer.set_chunk_size(value);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // One randomly shaped packet. Most are well formed with random content;
  // the rest carry surplus bytes, stop early, announce zero length, or are
  // stray bytes with no packet open.
  task automatic random_packet(input logic [7:0] size);
    int unsigned max_payload;
    int unsigned kind;
    int unsigned len;
    max_payload = (size < MinChunkSize) ? 1 : size - 1;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, (3 * max_payload + 1 < 40) ? 3 * max_payload + 1 : 40);
    if (kind < 70) begin
      send_packet(len, len);
    end else if (kind < 80) begin
      send_packet(len, len + $urandom_range(1, 3));
    end else if (kind < 90) begin
      // Length 7 to 65535, abandoned after 1 to 6 bytes by the next packet.
      send_packet($urandom_range(7, 65535), $urandom_range(1, 6));
    end else if (kind < 95) begin
      send_packet(0, $urandom_range(1, 3));
    end else begin
      send_byte(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Result sink: samples at the rising edge, chooses pop at the falling edge.
  // On request it holds pop low for a long stretch so that the command queue
  // fills and full is exercised.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) framer.check_beat(res_beat);
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold         = HoldOffCycles;
      end
      if (hold != 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("length_prefixed_chunk_segmenter_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned tail;
    int unsigned len;
    int unsigned sent;
    logic [7:0]  size;
    framer = new();
    phase  = 0;
    tail   = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset chunk size of 255.
    send_byte(1'b1, 16'd1, 8'h00);          // one-byte packet, zero payload
    send_byte(1'b1, 16'd2, 8'hFF);
    send_byte(1'b0, 16'h0000, 8'h5A);
    send_byte(1'b1, 16'd0, 8'h33);          // zero length drops this byte...
    send_byte(1'b0, 16'hFFFF, 8'h44);       // ...and the one after it
    send_byte(1'b1, 16'd1, 8'h11);
    send_byte(1'b0, 16'h0000, 8'h22);       // surplus byte after the packet
    send_byte(1'b1, 16'hFFFF, 8'h01);       // huge packet, abandoned early
    send_byte(1'b0, 16'h1234, 8'hFE);
    send_byte(1'b1, 16'd1, 8'h7F);          // restart without a terminator
    drain();

    // Smallest chunk: one payload byte per chunk, terminator always alone.
    write_chunk_size(8'd2);
    send_packet(3, 3);
    drain();
    // Sizes below two behave as two.
    write_chunk_size(8'd0);
    send_packet(2, 2);
    drain();
    write_chunk_size(8'd1);
    send_packet(1, 1);
    drain();
    // Size three: a full last chunk pushes the terminator out, a short one
    // takes it in.
    write_chunk_size(8'd3);
    send_packet(2, 2);
    send_packet(3, 3);

    // Random part, one chunk size per phase. A packet left open at the end
    // of a phase is finished after the size change. The stall phase and the
    // phase with no idling always run.
    framed_bytes = 0;
    while (phase < MinPhases || framed_bytes < FramedBytes) begin
      drain();
      if (phase == 0) begin
        size = 8'd255;
      end else begin
        case ($urandom_range(0, 9))
          0: size = 8'd2;
          1: size = 8'd255;
          2: size = 8'd254;
          default: size = 8'($urandom_range(3, 12));
        endcase
      end
      write_chunk_size(size);
      no_idle = (phase == 3);
      for (int unsigned i = 0; i < tail; i++) begin
        send_byte(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
      tail = 0;
      // The sink stalls while a steady packet keeps the input busy.
      if (phase == 2) begin
        hold_request = 1'b1;
        send_packet(20, 20);
      end
      repeat (3) random_packet(size);
      if ($urandom_range(0, 1) == 1) begin
        len  = $urandom_range(2, 30);
        sent = $urandom_range(1, len - 1);
        send_packet(len, sent);
        tail = len - sent;
      end
      phase++;
    end
    no_idle = 1'b0;
    drain();

    if (framer.errors == 0) begin
      $display("length_prefixed_chunk_segmenter_top verification clean");
    end else begin
      $display("length_prefixed_chunk_segmenter_top verification failed");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire

// ===== length_prefixed_chunk_segmenter_top.f =====
hdl/lpcs_pkg.sv
hdl/lpcs_front.sv
hdl/lpcs_fifo.sv
hdl/lpcs_back.sv
hdl/length_prefixed_chunk_segmenter_top.sv
dv/testbench.sv
